[rtl/cfot_pkg.sv]
// Shared constants, types and tables of the cyclic-prefix CFO tracker.
`timescale 1ns / 1ps
package cfot_pkg;

    localparam int MAX_FFT_DEF     = 4096;
    localparam int MAX_PREFIX_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int FFT_CFG_W   = 13;
    localparam int CP_CFG_W    = 11;
    localparam int SP_CFG_W    = 20;
    localparam int ALPHA_W     = 16;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 2;

    localparam int MIN_FFT     = 16;
    localparam int SP_MAX      = 960000;
    localparam int FREQ_W      = 28;
    localparam int FREQ_LIMIT  = 122880000;
    localparam int CODE_W      = 17;
    localparam int Z_W         = 17;
    localparam int ROT_W       = 33;
    localparam int NORM_BITS   = 30;
    localparam int STEP_W      = 4;
    localparam int LAST_STEP   = 15;
    localparam int HALF_PI     = 16384;
    localparam int FULL_PI     = 32768;
    localparam int Q_DEPTH     = 8;
    localparam int PIPE_SLOTS  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FFT_SIZE,
        CFG_CP_LENGTH,
        CFG_SPACING,
        CFG_ALPHA
    } t_cfg_idx;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_NORM,
        BK_ROT,
        BK_SCALE,
        BK_MUL_OLD,
        BK_MUL_NEW,
        BK_FINISH
    } t_bk_state;

    typedef struct packed {
        logic empty;
        logic room;
    } t_q_stat;

    typedef struct packed {
        logic pop;
        logic clr_filt;
        logic ld_abs;
        logic norm_shift;
        logic ld_rot;
        logic rot;
        logic ld_inst;
        logic mul_old;
        logic mul_new;
        logic emit;
    } t_bk_ctrl;

    function automatic int acc_width(input int sample_bits, input int max_prefix);
        int raw;
        raw = 2 * sample_bits + $clog2(max_prefix + 1) + 2;
        return (raw > 32) ? raw : 32;
    endfunction

    function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            4'd0:    v = Z_W'(8192);
            4'd1:    v = Z_W'(4836);
            4'd2:    v = Z_W'(2555);
            4'd3:    v = Z_W'(1297);
            4'd4:    v = Z_W'(651);
            4'd5:    v = Z_W'(326);
            4'd6:    v = Z_W'(163);
            4'd7:    v = Z_W'(81);
            4'd8:    v = Z_W'(41);
            4'd9:    v = Z_W'(20);
            4'd10:   v = Z_W'(10);
            4'd11:   v = Z_W'(5);
            4'd12:   v = Z_W'(3);
            4'd13:   v = Z_W'(1);
            4'd14:   v = Z_W'(1);
            default: v = Z_W'(0);
        endcase
        return v;
    endfunction

endpackage

[rtl/cfot_if.sv]
// Valid/ready channel interfaces for sample beats and estimate beats.
`timescale 1ns / 1ps
interface cfot_in_if #(
    parameter int SAMPLE_BITS = cfot_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;

    modport source (output valid, output func, output sample_re, output sample_im,
                    input ready);
    modport sink (input valid, input func, input sample_re, input sample_im,
                  output ready);
endinterface

interface cfot_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [cfot_pkg::FREQ_W-1:0]  freq_estimate;
    logic                                was_first;

    modport source (output valid, output freq_estimate, output was_first, input ready);
    modport sink (input valid, input freq_estimate, input was_first, output ready);
endinterface

[rtl/cfot_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cfot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/cfot_front.sv]
// Front part: symbol position, prefix store and lagged correlation pipeline.
`timescale 1ns / 1ps
module cfot_front #(
    parameter int MAX_FFT     = cfot_pkg::MAX_FFT_DEF,
    parameter int MAX_PREFIX  = cfot_pkg::MAX_PREFIX_DEF,
    parameter int SAMPLE_BITS = cfot_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_W       = cfot_pkg::acc_width(SAMPLE_BITS, MAX_PREFIX),
    parameter int FFT_W       = $clog2(MAX_FFT + 1),
    parameter int CPL_W       = $clog2(MAX_PREFIX + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cfot_in_if.sink            i_in,
    input  logic [FFT_W-1:0]   i_fft_size,
    input  logic [CPL_W-1:0]   i_cp_len,
    input  logic               i_room,
    output logic               o_push,
    output logic [2*ACC_W:0]   o_push_data
);
    localparam int POS_W = $clog2(MAX_FFT + MAX_PREFIX);
    localparam int AW    = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
    localparam int S     = SAMPLE_BITS;

    logic [POS_W-1:0] r_pos;
    logic [POS_W:0]   w_pos, w_n, w_cp, w_rel;
    logic             w_acc, w_hit_corr, w_hit_wr, w_last;
    logic [2*S-1:0]   w_rdata;

    logic                  r_s1_vld, r_s1_clr, r_s1_corr, r_s1_end;
    logic signed [S-1:0]   r_s1_re, r_s1_im;
    logic                  r_s2_vld, r_s2_clr, r_s2_corr, r_s2_end;
    logic signed [2*S-1:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri;
    logic signed [S-1:0]   w_pr, w_pi;

    logic signed [ACC_W-1:0] r_acc_re, r_acc_im;
    logic signed [ACC_W-1:0] w_term_re, w_term_im, w_sum_re, w_sum_im;

    assign i_in.ready = i_room;
    assign w_acc      = i_in.valid & i_room;

    assign w_pos      = {1'b0, r_pos};
    assign w_n        = (POS_W + 1)'(i_fft_size);
    assign w_cp       = (POS_W + 1)'(i_cp_len);
    assign w_rel      = w_pos - w_n;
    assign w_hit_corr = (w_pos >= w_n) && (w_rel < w_cp);
    assign w_hit_wr   = w_pos < w_cp;
    assign w_last     = (w_pos + (POS_W + 1)'(1)) >= (w_n + w_cp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_acc) begin
            if (i_in.func || w_last) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    cfot_ram #(
        .WIDTH (2 * S),
        .DEPTH (MAX_PREFIX),
        .AW    (AW)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc & ~i_in.func & w_hit_wr),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata ({i_in.sample_re, i_in.sample_im}),
        .i_raddr (w_rel[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_pr = $signed(w_rdata[2*S-1:S]);
    assign w_pi = $signed(w_rdata[S-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_clr  <= i_in.func;
        r_s1_corr <= ~i_in.func & w_hit_corr;
        r_s1_end  <= ~i_in.func & w_last;
        r_s1_re   <= i_in.sample_re;
        r_s1_im   <= i_in.sample_im;
        r_s2_clr  <= r_s1_clr;
        r_s2_corr <= r_s1_corr;
        r_s2_end  <= r_s1_end;
        r_p_rr    <= r_s1_re * w_pr;
        r_p_ii    <= r_s1_im * w_pi;
        r_p_ir    <= r_s1_im * w_pr;
        r_p_ri    <= r_s1_re * w_pi;
    end

    always_comb begin
        w_term_re = ACC_W'(r_p_rr) + ACC_W'(r_p_ii);
        w_term_im = ACC_W'(r_p_ir) - ACC_W'(r_p_ri);
        w_sum_re  = r_s2_corr ? (r_acc_re + w_term_re) : r_acc_re;
        w_sum_im  = r_s2_corr ? (r_acc_im + w_term_im) : r_acc_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_s2_vld) begin
            if (r_s2_clr || r_s2_end) begin
                r_acc_re <= '0;
                r_acc_im <= '0;
            end else begin
                r_acc_re <= w_sum_re;
                r_acc_im <= w_sum_im;
            end
        end
    end

    assign o_push      = r_s2_vld & (r_s2_clr | r_s2_end);
    assign o_push_data = {r_s2_clr, w_sum_re, w_sum_im};
endmodule

[rtl/cfot_fifo.sv]
// Short token queue between the correlation front and the estimate back.
`timescale 1ns / 1ps
module cfot_fifo #(
    parameter int WIDTH = 91,
    parameter int DEPTH = cfot_pkg::Q_DEPTH,
    parameter int SLOTS = cfot_pkg::PIPE_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output cfot_pkg::t_q_stat  o_stat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign w_push = i_push & (r_cnt != CW'(DEPTH));
    assign w_pop  = i_pop & (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.room  = (r_cnt <= CW'(DEPTH - SLOTS));
endmodule

[rtl/cfot_back.sv]
// Back part: CORDIC angle, frequency scaling, exponential averaging and output beat.
`timescale 1ns / 1ps
module cfot_back #(
    parameter int ACC_W = 45
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [2*ACC_W:0]                  i_tok_data,
    input  cfot_pkg::t_q_stat                 i_stat,
    output logic                              o_pop,
    input  logic [cfot_pkg::SP_CFG_W-1:0]     i_spacing,
    input  logic [cfot_pkg::ALPHA_W-1:0]      i_alpha,
    cfot_out_if.source                        o_out
);
    localparam int FW  = cfot_pkg::FREQ_W;
    localparam int ZW  = cfot_pkg::Z_W;
    localparam int RW  = cfot_pkg::ROT_W;
    localparam int NB  = cfot_pkg::NORM_BITS;
    localparam int CW  = cfot_pkg::CODE_W;
    localparam int SW  = cfot_pkg::SP_CFG_W;
    localparam int AWT = cfot_pkg::ALPHA_W;
    localparam int PAW = AWT + 1 + FW;
    localparam int PBW = AWT + 2 + FW;
    localparam int SPW = CW + SW + 1;

    cfot_pkg::t_bk_state r_state, n_state;
    cfot_pkg::t_bk_ctrl  w_ctl;

    logic                    w_tok_clr, w_big, w_out_free;
    logic signed [ACC_W-1:0] w_tok_re, w_tok_im;
    logic [ACC_W-1:0]        r_ax, r_ay;
    logic                    r_x_neg, r_y_neg;
    logic signed [RW-1:0]    r_cx, r_cy, w_dx, w_dy;
    logic signed [ZW-1:0]    r_z, w_zc;
    logic [cfot_pkg::STEP_W-1:0] r_it;
    logic signed [CW-1:0]    w_code, w_zf;
    logic signed [SW:0]      w_sp;
    logic signed [SPW-1:0]   w_scaled;
    logic signed [FW-1:0]    r_inst, r_smooth, w_avg, w_next;
    logic                    r_started;
    logic signed [AWT:0]     w_alpha;
    logic signed [AWT+1:0]   w_weight;
    logic signed [PAW-1:0]   r_prod_a;
    logic signed [PBW-1:0]   r_prod_b, w_psum;
    logic                    r_out_vld, r_out_first;
    logic signed [FW-1:0]    r_out_freq;

    assign w_tok_clr  = i_tok_data[2*ACC_W];
    assign w_tok_re   = $signed(i_tok_data[2*ACC_W-1:ACC_W]);
    assign w_tok_im   = $signed(i_tok_data[ACC_W-1:0]);
    assign w_big      = (|r_ax[ACC_W-1:NB]) | (|r_ay[ACC_W-1:NB]);
    assign w_out_free = ~r_out_vld | o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cfot_pkg::BK_IDLE: begin
                if (!i_stat.empty && !w_tok_clr) begin
                    n_state = cfot_pkg::BK_NORM;
                end
            end
            cfot_pkg::BK_NORM: begin
                if (!w_big) begin
                    n_state = cfot_pkg::BK_ROT;
                end
            end
            cfot_pkg::BK_ROT: begin
                if (r_it == cfot_pkg::STEP_W'(cfot_pkg::LAST_STEP)) begin
                    n_state = cfot_pkg::BK_SCALE;
                end
            end
            cfot_pkg::BK_SCALE:   n_state = cfot_pkg::BK_MUL_OLD;
            cfot_pkg::BK_MUL_OLD: n_state = cfot_pkg::BK_MUL_NEW;
            cfot_pkg::BK_MUL_NEW: n_state = cfot_pkg::BK_FINISH;
            cfot_pkg::BK_FINISH: begin
                if (w_out_free) begin
                    n_state = cfot_pkg::BK_IDLE;
                end
            end
            default: n_state = cfot_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        w_ctl = '0;
        case (r_state)
            cfot_pkg::BK_IDLE: begin
                w_ctl.pop      = ~i_stat.empty;
                w_ctl.clr_filt = ~i_stat.empty & w_tok_clr;
                w_ctl.ld_abs   = ~i_stat.empty & ~w_tok_clr;
            end
            cfot_pkg::BK_NORM: begin
                w_ctl.norm_shift = w_big;
                w_ctl.ld_rot     = ~w_big;
            end
            cfot_pkg::BK_ROT:     w_ctl.rot     = 1'b1;
            cfot_pkg::BK_SCALE:   w_ctl.ld_inst = 1'b1;
            cfot_pkg::BK_MUL_OLD: w_ctl.mul_old = 1'b1;
            cfot_pkg::BK_MUL_NEW: w_ctl.mul_new = 1'b1;
            cfot_pkg::BK_FINISH:  w_ctl.emit    = w_out_free;
            default:              w_ctl         = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfot_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_pop = w_ctl.pop;

    assign w_dx = r_cy >>> r_it;
    assign w_dy = r_cx >>> r_it;

    always_comb begin
        if (r_z < 0) begin
            w_zc = '0;
        end else if (r_z > ZW'(cfot_pkg::HALF_PI)) begin
            w_zc = ZW'(cfot_pkg::HALF_PI);
        end else begin
            w_zc = r_z;
        end
        w_zf     = r_x_neg ? (CW'(cfot_pkg::FULL_PI) - CW'(w_zc)) : CW'(w_zc);
        w_code   = r_y_neg ? -w_zf : w_zf;
        w_sp     = $signed({1'b0, i_spacing});
        w_scaled = w_code * w_sp;
        w_alpha  = $signed({1'b0, i_alpha});
        w_weight = $signed((AWT + 2)'(1 << AWT)) - (AWT + 2)'(w_alpha);
        w_psum   = PBW'(r_prod_a) + r_prod_b;
        w_avg    = FW'(w_psum >>> AWT);
        w_next   = r_started ? w_avg : r_inst;
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ld_abs) begin
            r_x_neg <= w_tok_re[ACC_W-1];
            r_y_neg <= w_tok_im[ACC_W-1];
            r_ax    <= w_tok_re[ACC_W-1] ? ACC_W'(-w_tok_re) : ACC_W'(w_tok_re);
            r_ay    <= w_tok_im[ACC_W-1] ? ACC_W'(-w_tok_im) : ACC_W'(w_tok_im);
        end else if (w_ctl.norm_shift) begin
            r_ax <= r_ax >> 1;
            r_ay <= r_ay >> 1;
        end
        if (w_ctl.ld_rot) begin
            r_cx <= $signed({(RW - NB)'(0), r_ax[NB-1:0]});
            r_cy <= $signed({(RW - NB)'(0), r_ay[NB-1:0]});
            r_z  <= '0;
            r_it <= '0;
        end else if (w_ctl.rot) begin
            if (r_cy > 0) begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_z  <= r_z + cfot_pkg::atan_step(r_it);
            end else if (r_cy < 0) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_z  <= r_z - cfot_pkg::atan_step(r_it);
            end
            r_it <= r_it + cfot_pkg::STEP_W'(1);
        end
        if (w_ctl.ld_inst) begin
            r_inst <= FW'(w_scaled >>> 8);
        end
        if (w_ctl.mul_old) begin
            r_prod_a <= w_alpha * r_smooth;
        end
        if (w_ctl.mul_new) begin
            r_prod_b <= w_weight * r_inst;
        end
        if (w_ctl.emit) begin
            r_out_freq  <= w_next;
            r_out_first <= ~r_started;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth  <= '0;
            r_started <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_ctl.clr_filt) begin
                r_smooth  <= '0;
                r_started <= 1'b0;
            end else if (w_ctl.emit) begin
                r_smooth  <= w_next;
                r_started <= 1'b1;
            end
            if (w_ctl.emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.freq_estimate = r_out_freq;
    assign o_out.was_first     = r_out_first;
endmodule

[rtl/cp_correlation_cfo_tracker_core.sv]
// Top level of the cyclic-prefix carrier frequency offset tracker.
// Samples are taken at one beat per cycle while the queue has room. Each
// sample passes a three-stage correlation pipeline (prefix RAM read, four
// products, accumulate); at the last sample of a symbol the correlation sums
// move through an eight-entry queue to a sequential back end, which pops the
// token, halves the sums while they are 2^30 or above (at most ACC_W-30
// halvings), loads and runs the CORDIC, then scales, averages and registers
// the output; it pops no new token until it has finished the last one. Input
// ready drops only while that queue is nearly full, i.e. when symbols arrive
// faster than the back end can process them. A clear beat travels through
// the same queue and resets the filter in order. The prefix store has no
// reset; no clearing pass is needed.
`timescale 1ns / 1ps
module cp_correlation_cfo_tracker_core #(
    parameter int MAX_FFT     = cfot_pkg::MAX_FFT_DEF,
    parameter int MAX_PREFIX  = cfot_pkg::MAX_PREFIX_DEF,
    parameter int SAMPLE_BITS = cfot_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    cfot_in_if.sink                             i_in,
    cfot_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [cfot_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cfot_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int ACC_W = cfot_pkg::acc_width(SAMPLE_BITS, MAX_PREFIX);
    localparam int FFT_W = $clog2(MAX_FFT + 1);
    localparam int CPL_W = $clog2(MAX_PREFIX + 1);
    localparam int TOK_W = 2 * ACC_W + 1;

    logic [cfot_pkg::FFT_CFG_W-1:0] r_fft;
    logic [cfot_pkg::CP_CFG_W-1:0]  r_cp;
    logic [cfot_pkg::SP_CFG_W-1:0]  r_sp;
    logic [cfot_pkg::ALPHA_W-1:0]   r_alpha;

    logic [FFT_W-1:0]               w_fft;
    logic [CPL_W-1:0]               w_cp;
    logic [cfot_pkg::SP_CFG_W-1:0]  w_sp;

    logic                           w_push, w_pop;
    logic [TOK_W-1:0]               w_push_data, w_tok;
    cfot_pkg::t_q_stat              w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fft   <= cfot_pkg::FFT_CFG_W'(1024);
            r_cp    <= cfot_pkg::CP_CFG_W'(72);
            r_sp    <= cfot_pkg::SP_CFG_W'(15000);
            r_alpha <= cfot_pkg::ALPHA_W'(58982);
        end else if (i_cfg_we) begin
            case (cfot_pkg::t_cfg_idx'(i_cfg_idx))
                cfot_pkg::CFG_FFT_SIZE:  r_fft   <= i_cfg_data[cfot_pkg::FFT_CFG_W-1:0];
                cfot_pkg::CFG_CP_LENGTH: r_cp    <= i_cfg_data[cfot_pkg::CP_CFG_W-1:0];
                cfot_pkg::CFG_SPACING:   r_sp    <= i_cfg_data[cfot_pkg::SP_CFG_W-1:0];
                cfot_pkg::CFG_ALPHA:     r_alpha <= i_cfg_data[cfot_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(r_fft) < cfot_pkg::MIN_FFT) begin
            w_fft = FFT_W'(cfot_pkg::MIN_FFT);
        end else if (32'(r_fft) > MAX_FFT) begin
            w_fft = FFT_W'(MAX_FFT);
        end else begin
            w_fft = FFT_W'(r_fft);
        end
        if (32'(r_cp) > MAX_PREFIX) begin
            w_cp = CPL_W'(MAX_PREFIX);
        end else begin
            w_cp = CPL_W'(r_cp);
        end
        if (32'(r_sp) > cfot_pkg::SP_MAX) begin
            w_sp = cfot_pkg::SP_CFG_W'(cfot_pkg::SP_MAX);
        end else begin
            w_sp = r_sp;
        end
    end

    cfot_front #(
        .MAX_FFT     (MAX_FFT),
        .MAX_PREFIX  (MAX_PREFIX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W),
        .FFT_W       (FFT_W),
        .CPL_W       (CPL_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_fft_size  (w_fft),
        .i_cp_len    (w_cp),
        .i_room      (w_stat.room),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    cfot_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (cfot_pkg::Q_DEPTH),
        .SLOTS (cfot_pkg::PIPE_SLOTS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_tok),
        .o_stat  (w_stat)
    );

    cfot_back #(
        .ACC_W (ACC_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok_data (w_tok),
        .i_stat     (w_stat),
        .o_pop      (w_pop),
        .i_spacing  (w_sp),
        .i_alpha    (r_alpha),
        .o_out      (o_out)
    );
endmodule

[rtl/cfot_check.sv]
// Port-level checker for the CFO tracker, bound to the top level.
`timescale 1ns / 1ps
module cfot_check (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [cfot_pkg::FREQ_W-1:0]  i_freq,
    input logic                                i_first
);
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("estimate beat shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_freq) && $stable(i_first))
        else $error("stalled estimate beat changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_freq >= -cfot_pkg::FREQ_LIMIT) && (i_freq <= cfot_pkg::FREQ_LIMIT))
        else $error("estimate outside the offset range");
endmodule

bind cp_correlation_cfo_tracker_core cfot_check u_cfot_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_freq      (o_out.freq_estimate),
    .i_first     (o_out.was_first)
);
